FILE: src/mm_pkg.sv
// mm_pkg: shared sizes, config codes, control word layout and the microcode rom
// for the matrix multiply block. No dependencies.
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int ELEM_BITS = 16;

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int LEN_W   = 2 * DIM_W;
    localparam int PROD_W  = 2 * ELEM_BITS;
    localparam int SUM_W   = 40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0]  REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0]  REG_COLS_B    = 2'd2;
    localparam logic [CFG_DATA_W-1:0] CFG_RESET     = 4'd8;

    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] STEP_INIT = 3'd0;
    localparam logic [PC_W-1:0] STEP_ELEM = 3'd1;
    localparam logic [PC_W-1:0] STEP_READ = 3'd2;
    localparam logic [PC_W-1:0] STEP_MUL  = 3'd3;
    localparam logic [PC_W-1:0] STEP_ACC  = 3'd4;
    localparam logic [PC_W-1:0] STEP_EMIT = 3'd5;
    localparam logic [PC_W-1:0] STEP_NEXT = 3'd6;
    localparam logic [PC_W-1:0] STEP_DONE = 3'd7;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_MORE_TERMS,
        COND_OUT_BUSY,
        COND_NOT_LAST
    } cond_t;

    typedef struct packed {
        logic init_idx;
        logic start_elem;
        logic mem_rd;
        logic mul_en;
        logic acc_en;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic more_terms;
        logic out_busy;
        logic last;
    } status_t;

    typedef struct packed {
        ctrl_t             ctrl;
        logic              done;
        cond_t             cond;
        logic [PC_W-1:0]   target;
    } ucode_t;

    typedef struct packed {
        logic [DIM_W-1:0] m;
        logic [DIM_W-1:0] k;
        logic [DIM_W-1:0] n;
    } dims_t;

    // zero reads as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        w.cond = COND_NONE;
        case (pc)
            STEP_INIT: w.ctrl.init_idx = 1'b1;
            STEP_ELEM: w.ctrl.start_elem = 1'b1;
            STEP_READ: w.ctrl.mem_rd = 1'b1;
            STEP_MUL:  w.ctrl.mul_en = 1'b1;
            STEP_ACC:
            begin
                w.ctrl.acc_en = 1'b1;
                w.cond        = COND_MORE_TERMS;
                w.target      = STEP_READ;
            end
            STEP_EMIT:
            begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_OUT_BUSY;
                w.target    = STEP_EMIT;
            end
            STEP_NEXT:
            begin
                w.cond   = COND_NOT_LAST;
                w.target = STEP_ELEM;
            end
            STEP_DONE: w.done = 1'b1;
            default:   w.done = 1'b1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: src/mm_ram.sv
// mm_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
`default_nettype none

module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: src/mm_seq.sv
// mm_seq: step counter and microcode rom that drive the multiply datapath.
// Depends on mm_pkg.
`default_nettype none

module mm_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire mm_pkg::status_t status,
    output mm_pkg::ctrl_t        ctrl,
    output logic                 running
);

    logic                    running_reg;
    logic [mm_pkg::PC_W-1:0] pc_reg;
    logic [mm_pkg::PC_W-1:0] pc_next;
    mm_pkg::ucode_t          word;
    logic                    cond_true;

    assign word = mm_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        case (word.cond)
            mm_pkg::COND_MORE_TERMS: cond_true = status.more_terms;
            mm_pkg::COND_OUT_BUSY:   cond_true = status.out_busy;
            mm_pkg::COND_NOT_LAST:   cond_true = !status.last;
            default:                 cond_true = 1'b0;
        endcase
        pc_next = cond_true ? word.target : pc_reg + 1'b1;
    end

    always_comb
    begin
        ctrl = running_reg ? word.ctrl : '0;
        // hold the result until the output register frees up
        ctrl.emit = running_reg && word.ctrl.emit && !status.out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            pc_reg      <= mm_pkg::STEP_INIT;
        end
        else if (start)
        begin
            running_reg <= 1'b1;
            pc_reg      <= mm_pkg::STEP_INIT;
        end
        else if (running_reg)
        begin
            if (word.done)
                running_reg <= 1'b0;
            pc_reg <= pc_next;
        end
    end

    assign running = running_reg;

endmodule

`default_nettype wire

FILE: src/mm_datapath.sv
// mm_datapath: index counters, multiplier, accumulator and output register.
// Depends on mm_pkg; operands come from the two mm_ram stores.
`default_nettype none

module mm_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mm_pkg::ctrl_t                   ctrl,
    input  wire mm_pkg::dims_t                   dims,
    input  wire logic [mm_pkg::ELEM_BITS-1:0]    a_data,
    input  wire logic [mm_pkg::ELEM_BITS-1:0]    b_data,
    output logic      [mm_pkg::ADDR_W-1:0]       a_addr,
    output logic      [mm_pkg::ADDR_W-1:0]       b_addr,
    output mm_pkg::status_t                      status,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [mm_pkg::IDX_W-1:0]        out_row,
    output logic      [mm_pkg::IDX_W-1:0]        out_col,
    output logic signed [mm_pkg::SUM_W-1:0]      product_value,
    output logic                                 final_flag
);

    logic [mm_pkg::IDX_W-1:0]         i_reg;
    logic [mm_pkg::IDX_W-1:0]         j_reg;
    logic [mm_pkg::IDX_W-1:0]         t_reg;
    logic [mm_pkg::ADDR_W-1:0]        abase_reg;
    logic [mm_pkg::ADDR_W-1:0]        a_addr_reg;
    logic [mm_pkg::ADDR_W-1:0]        b_addr_reg;
    logic signed [mm_pkg::PROD_W-1:0] prod_reg;
    logic signed [mm_pkg::SUM_W-1:0]  acc_reg;
    logic                             last_reg;
    logic                             out_valid_reg;
    logic [mm_pkg::IDX_W-1:0]         out_row_reg;
    logic [mm_pkg::IDX_W-1:0]         out_col_reg;
    logic signed [mm_pkg::SUM_W-1:0]  out_value_reg;
    logic                             out_final_reg;

    logic row_end;
    logic col_end;
    logic last_now;

    assign row_end  = (i_reg == mm_pkg::IDX_W'(dims.m - 1'b1));
    assign col_end  = (j_reg == mm_pkg::IDX_W'(dims.n - 1'b1));
    assign last_now = row_end && col_end;

    assign status.more_terms = (t_reg != mm_pkg::IDX_W'(dims.k - 1'b1));
    assign status.out_busy   = out_valid_reg && !out_ready;
    assign status.last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.init_idx)
        begin
            i_reg     <= '0;
            j_reg     <= '0;
            abase_reg <= '0;
        end
        if (ctrl.start_elem)
        begin
            t_reg      <= '0;
            a_addr_reg <= abase_reg;
            b_addr_reg <= mm_pkg::ADDR_W'(j_reg);
            acc_reg    <= '0;
        end
        if (ctrl.mul_en)
            prod_reg <= $signed(a_data) * $signed(b_data);
        if (ctrl.acc_en)
        begin
            acc_reg    <= acc_reg + mm_pkg::SUM_W'(prod_reg);
            t_reg      <= t_reg + 1'b1;
            a_addr_reg <= a_addr_reg + 1'b1;
            // next row of b sits one row length further on
            b_addr_reg <= b_addr_reg + mm_pkg::ADDR_W'(dims.n);
        end
        if (ctrl.emit)
        begin
            out_row_reg   <= i_reg;
            out_col_reg   <= j_reg;
            out_value_reg <= acc_reg;
            out_final_reg <= last_now;
            last_reg      <= last_now;
            if (col_end)
            begin
                j_reg     <= '0;
                i_reg     <= i_reg + 1'b1;
                abase_reg <= abase_reg + mm_pkg::ADDR_W'(dims.k);
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    assign a_addr        = a_addr_reg;
    assign b_addr        = b_addr_reg;
    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = out_value_reg;
    assign final_flag    = out_final_reg;

endmodule

`default_nettype wire

FILE: src/matrix_multiply.sv
// matrix_multiply: loads A then B one element per cycle while the sequencer is idle;
// after the last B element the microcoded sequencer works out C in row-major order,
// each term going through the read, multiply and accumulate steps.
// Reset clears the load count and the sequencer and sets all sizes to 8; store
// contents stay undefined until written, with no clearing pass.
`default_nettype none

module matrix_multiply (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [mm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [mm_pkg::ELEM_BITS-1:0]  element,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [mm_pkg::IDX_W-1:0]                  out_row,
    output logic [mm_pkg::IDX_W-1:0]                  out_col,
    output logic signed [mm_pkg::SUM_W-1:0]           product_value,
    output logic                                      final_flag
);

    mm_pkg::dims_t            dims_reg;
    logic [mm_pkg::ADDR_W-1:0] idx_reg;
    logic                     phase_b_reg;
    logic [mm_pkg::LEN_W-1:0] a_len;
    logic [mm_pkg::LEN_W-1:0] b_len;
    logic [mm_pkg::LEN_W-1:0] idx_plus;
    logic                     cfg_fire;
    logic                     cfg_hit;
    logic                     in_fire;
    logic                     a_wr;
    logic                     b_wr;
    logic                     start;
    logic                     running;
    mm_pkg::ctrl_t            ctrl;
    mm_pkg::status_t          status;
    logic [mm_pkg::ADDR_W-1:0]    a_addr;
    logic [mm_pkg::ADDR_W-1:0]    b_addr;
    logic [mm_pkg::ELEM_BITS-1:0] a_data;
    logic [mm_pkg::ELEM_BITS-1:0] b_data;

    assign cfg_ready = 1'b1;
    assign in_ready  = !running;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_fire && (cfg_index == mm_pkg::REG_ROWS_A
                                    || cfg_index == mm_pkg::REG_INNER_LEN
                                    || cfg_index == mm_pkg::REG_COLS_B);
    assign in_fire   = in_valid && in_ready;

    assign a_len    = dims_reg.m * dims_reg.k;
    assign b_len    = dims_reg.k * dims_reg.n;
    assign idx_plus = mm_pkg::LEN_W'(idx_reg) + 1'b1;

    assign a_wr  = in_fire && !phase_b_reg;
    assign b_wr  = in_fire && phase_b_reg;
    assign start = b_wr && (idx_plus == b_len) && !cfg_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.m  <= mm_pkg::eff_dim(mm_pkg::CFG_RESET);
            dims_reg.k  <= mm_pkg::eff_dim(mm_pkg::CFG_RESET);
            dims_reg.n  <= mm_pkg::eff_dim(mm_pkg::CFG_RESET);
            idx_reg     <= '0;
            phase_b_reg <= 1'b0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                mm_pkg::REG_ROWS_A:    dims_reg.m <= mm_pkg::eff_dim(cfg_data);
                mm_pkg::REG_INNER_LEN: dims_reg.k <= mm_pkg::eff_dim(cfg_data);
                mm_pkg::REG_COLS_B:    dims_reg.n <= mm_pkg::eff_dim(cfg_data);
                default:               dims_reg   <= dims_reg;
            endcase
            // a size change restarts the load
            idx_reg     <= '0;
            phase_b_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (idx_plus == (phase_b_reg ? b_len : a_len))
            begin
                idx_reg     <= '0;
                phase_b_reg <= !phase_b_reg;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    mm_ram #(
        .WIDTH (mm_pkg::ELEM_BITS),
        .DEPTH (mm_pkg::DEPTH)
    ) u_a_store (
        .clk     (clk),
        .wr_en   (a_wr),
        .wr_addr (idx_reg),
        .wr_data (element),
        .rd_en   (ctrl.mem_rd),
        .rd_addr (a_addr),
        .rd_data (a_data)
    );

    mm_ram #(
        .WIDTH (mm_pkg::ELEM_BITS),
        .DEPTH (mm_pkg::DEPTH)
    ) u_b_store (
        .clk     (clk),
        .wr_en   (b_wr),
        .wr_addr (idx_reg),
        .wr_data (element),
        .rd_en   (ctrl.mem_rd),
        .rd_addr (b_addr),
        .rd_data (b_data)
    );

    mm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .status  (status),
        .ctrl    (ctrl),
        .running (running)
    );

    mm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .dims          (dims_reg),
        .a_data        (a_data),
        .b_data        (b_data),
        .a_addr        (a_addr),
        .b_addr        (b_addr),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .final_flag    (final_flag)
    );

endmodule

`default_nettype wire

FILE: src/mm_checker.sv
// mm_checker: port-level assertions for matrix_multiply, bound to the top level.
// Depends on mm_pkg.
`default_nettype none

module mm_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_ready,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic [mm_pkg::IDX_W-1:0]             out_row,
    input wire logic [mm_pkg::IDX_W-1:0]             out_col,
    input wire logic signed [mm_pkg::SUM_W-1:0]      product_value,
    input wire logic                                 final_flag
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(product_value) && $stable(out_row)
                                    && $stable(out_col) && $stable(final_flag))
        else $error("stalled result changed");

    // while results of a matrix are still coming, no new element is taken
    a_busy_mid_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !final_flag |-> !in_ready)
        else $error("input taken before matrix finished");

    a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result appeared while loading");

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);

`default_nettype wire
